>>> hdl/hss_pkg.sv
// ---------------------------------------------------------------------------
// Hair strand shading package
// Shared types, register indexes, reset values and pipeline sizes.
// ---------------------------------------------------------------------------
package hss_pkg;

	localparam int unsigned ONE_Q15    = 32768;
	localparam int unsigned SQRT_STEPS = 16;
	localparam int unsigned POW_STAGES = 255;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_DIFFUSE_RED    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DIFFUSE_GREEN  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DIFFUSE_BLUE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPECULAR_RED   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPECULAR_GREEN = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SPECULAR_BLUE  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SHININESS      = 3'd6;

	localparam logic [15:0] RST_DIFFUSE_RED   = 16'd1311;
	localparam logic [15:0] RST_DIFFUSE_GREEN = 16'd934;
	localparam logic [15:0] RST_DIFFUSE_BLUE  = 16'd524;
	localparam logic [15:0] RST_SPECULAR      = 16'd4096;
	localparam logic [7:0]  RST_SHININESS     = 8'd50;

	typedef struct packed {
		logic signed [15:0] tx, ty, tz;
		logic signed [15:0] lx, ly, lz;
		logic signed [15:0] ex, ey, ez;
	} vec_set_t;

	typedef struct packed {
		logic [15:0] red, green, blue;
	} rgb_t;

	// Common pipeline control: advance enable and the valid bit entering a part.
	typedef struct packed {
		logic en;
		logic valid;
	} pipe_ctl_t;

endpackage

>>> hdl/hss_in_if.sv
// ---------------------------------------------------------------------------
// Sample input channel
// Valid/ready channel carrying tangent, light and eye vectors in Q1.15.
// ---------------------------------------------------------------------------
interface hss_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] tangent_x, tangent_y, tangent_z;
	logic signed [15:0] light_x, light_y, light_z;
	logic signed [15:0] eye_x, eye_y, eye_z;

	modport source (output valid, tangent_x, tangent_y, tangent_z, light_x, light_y,
		light_z, eye_x, eye_y, eye_z, input ready);
	modport sink (input valid, tangent_x, tangent_y, tangent_z, light_x, light_y,
		light_z, eye_x, eye_y, eye_z, output ready);
endinterface

>>> hdl/hss_out_if.sv
// ---------------------------------------------------------------------------
// Shaded colour output channel
// Valid/ready channel carrying the saturated Q4.12 colour.
// ---------------------------------------------------------------------------
interface hss_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] color_red, color_green, color_blue;

	modport source (output valid, color_red, color_green, color_blue, input ready);
	modport sink (input valid, color_red, color_green, color_blue, output ready);
endinterface

>>> hdl/hss_cfg_if.sv
// ---------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and write data.
// ---------------------------------------------------------------------------
interface hss_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [hss_pkg::CFG_IDX_W-1:0]      index;
	logic [hss_pkg::CFG_DATA_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> hdl/hss_dot.sv
// ---------------------------------------------------------------------------
// Cosine and radicand stages
// Three stages: products, Q.15 cosines, clamped radicands 1 - cos^2.
// ---------------------------------------------------------------------------
module hss_dot (
	input  logic               clk,
	input  logic               arst_n,
	input  hss_pkg::pipe_ctl_t ctl,
	input  hss_pkg::vec_set_t  vec,
	output logic               valid,
	output logic signed [17:0] cos_tl,
	output logic signed [17:0] cos_te,
	output logic [30:0]        rad_tl,
	output logic [30:0]        rad_te
);

	logic               valid_s1, valid_s2, valid_s3;
	logic signed [31:0] ptl_s1 [3];
	logic signed [31:0] pte_s1 [3];
	logic signed [17:0] ctl_s2, cte_s2;
	logic signed [17:0] ctl_s3, cte_s3;
	logic [30:0]        rtl_s3, rte_s3;

	logic signed [33:0] dot_tl, dot_te;
	logic signed [35:0] sq_tl, sq_te;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (ctl.en) begin
			valid_s1 <= ctl.valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	assign dot_tl = 34'(ptl_s1[0]) + 34'(ptl_s1[1]) + 34'(ptl_s1[2]);
	assign dot_te = 34'(pte_s1[0]) + 34'(pte_s1[1]) + 34'(pte_s1[2]);
	assign sq_tl  = ctl_s2 * ctl_s2;
	assign sq_te  = cte_s2 * cte_s2;

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			ptl_s1[0] <= vec.lx * vec.tx;
			ptl_s1[1] <= vec.ly * vec.ty;
			ptl_s1[2] <= vec.lz * vec.tz;
			pte_s1[0] <= vec.ex * vec.tx;
			pte_s1[1] <= vec.ey * vec.ty;
			pte_s1[2] <= vec.ez * vec.tz;
			// The dot product stays within 33 signed bits, so this slice is the floor.
			ctl_s2 <= dot_tl[32:15];
			cte_s2 <= dot_te[32:15];
			ctl_s3 <= ctl_s2;
			cte_s3 <= cte_s2;
			rtl_s3 <= (sq_tl > 36'sd1073741824) ? 31'd0 : 31'(36'sd1073741824 - sq_tl);
			rte_s3 <= (sq_te > 36'sd1073741824) ? 31'd0 : 31'(36'sd1073741824 - sq_te);
		end
	end

	assign valid  = valid_s3;
	assign cos_tl = ctl_s3;
	assign cos_te = cte_s3;
	assign rad_tl = rtl_s3;
	assign rad_te = rte_s3;

endmodule

>>> hdl/hss_sqrt.sv
// ---------------------------------------------------------------------------
// Pipelined square root
// Two lanes of digit-by-digit square root, one result bit per stage, with
// the cosines carried alongside.
// ---------------------------------------------------------------------------
module hss_sqrt (
	input  logic               clk,
	input  logic               arst_n,
	input  hss_pkg::pipe_ctl_t ctl,
	input  logic signed [17:0] cos_tl_in,
	input  logic signed [17:0] cos_te_in,
	input  logic [30:0]        rad_tl,
	input  logic [30:0]        rad_te,
	output logic               valid,
	output logic signed [17:0] cos_tl,
	output logic signed [17:0] cos_te,
	output logic [15:0]        sin_tl,
	output logic [15:0]        sin_te
);

	localparam int unsigned N = hss_pkg::SQRT_STEPS;

	typedef struct packed {
		logic [31:0] rad;
		logic [17:0] rem;
		logic [15:0] root;
	} sq_t;

	function automatic sq_t sq_step(input sq_t cur);
		logic [19:0] acc;
		logic [19:0] trial;
		sq_t         nxt;
		acc   = {cur.rem, cur.rad[31:30]};
		trial = {2'b00, cur.root, 2'b01};
		nxt.rad = {cur.rad[29:0], 2'b00};
		if (acc >= trial) begin
			nxt.rem  = 18'(acc - trial);
			nxt.root = {cur.root[14:0], 1'b1};
		end else begin
			nxt.rem  = acc[17:0];
			nxt.root = {cur.root[14:0], 1'b0};
		end
		return nxt;
	endfunction

	logic               valid_s [N];
	sq_t                lane_s  [N][2];
	logic signed [17:0] ctl_s   [N];
	logic signed [17:0] cte_s   [N];

	sq_t seed [2];
	assign seed[0] = '{rad: {1'b0, rad_tl}, rem: '0, root: '0};
	assign seed[1] = '{rad: {1'b0, rad_te}, rem: '0, root: '0};

	for (genvar k = 0; k < N; k++) begin : g_step
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (ctl.en) begin
				valid_s[k] <= (k == 0) ? ctl.valid : valid_s[(k == 0) ? 0 : k-1];
			end
		end
		always_ff @(posedge clk) begin
			if (ctl.en) begin
				if (k == 0) begin
					lane_s[k][0] <= sq_step(seed[0]);
					lane_s[k][1] <= sq_step(seed[1]);
					ctl_s[k]     <= cos_tl_in;
					cte_s[k]     <= cos_te_in;
				end else begin
					lane_s[k][0] <= sq_step(lane_s[(k == 0) ? 0 : k-1][0]);
					lane_s[k][1] <= sq_step(lane_s[(k == 0) ? 0 : k-1][1]);
					ctl_s[k]     <= ctl_s[(k == 0) ? 0 : k-1];
					cte_s[k]     <= cte_s[(k == 0) ? 0 : k-1];
				end
			end
		end
	end

	assign valid  = valid_s[N-1];
	assign cos_tl = ctl_s[N-1];
	assign cos_te = cte_s[N-1];
	assign sin_tl = lane_s[N-1][0].root;
	assign sin_te = lane_s[N-1][1].root;

endmodule

>>> hdl/hss_pow.sv
// ---------------------------------------------------------------------------
// Specular factor pipeline
// Forms the cosine-difference base, classifies it, then raises it to the
// shininess exponent with one truncating Q.15 multiply per stage.
// ---------------------------------------------------------------------------
module hss_pow (
	input  logic               clk,
	input  logic               arst_n,
	input  hss_pkg::pipe_ctl_t ctl,
	input  logic [7:0]         shininess,
	input  logic signed [17:0] cos_tl,
	input  logic signed [17:0] cos_te,
	input  logic [15:0]        sin_tl_in,
	input  logic [15:0]        sin_te,
	output logic               valid,
	output logic [15:0]        sin_tl,
	output logic [15:0]        factor
);

	localparam int unsigned N = hss_pkg::POW_STAGES;

	logic               valid_b1, valid_b2;
	logic signed [35:0] pc_b1;
	logic [31:0]        ps_b1;
	logic [15:0]        sin_b1;

	logic signed [36:0] sum;
	logic signed [21:0] base_full;

	logic               valid_s [N+1];
	logic [15:0]        f_s     [N+1];
	logic [14:0]        base_s  [N+1];
	logic               mul_s   [N+1];
	logic [15:0]        sin_s   [N+1];

	assign sum       = pc_b1 + 37'(signed'({1'b0, ps_b1}));
	assign base_full = sum[36:15];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_b1 <= 1'b0;
			valid_s[0] <= 1'b0;
		end else if (ctl.en) begin
			valid_b1 <= ctl.valid;
			valid_s[0] <= valid_b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			pc_b1  <= cos_tl * cos_te;
			ps_b1  <= sin_tl_in * sin_te;
			sin_b1 <= sin_tl_in;
			sin_s[0]  <= sin_b1;
			base_s[0] <= base_full[14:0];
			priority if (base_full <= 22'sd0) begin
				f_s[0]   <= 16'd0;
				mul_s[0] <= 1'b0;
			end else if (base_full >= 22'sd32768) begin
				f_s[0]   <= 16'(hss_pkg::ONE_Q15);
				mul_s[0] <= 1'b0;
			end else begin
				f_s[0]   <= 16'(hss_pkg::ONE_Q15);
				mul_s[0] <= 1'b1;
			end
		end
	end

	for (genvar k = 0; k < N; k++) begin : g_mul
		logic [30:0] prod;
		assign prod = f_s[k] * base_s[k];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else if (ctl.en) begin
				valid_s[k+1] <= valid_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (ctl.en) begin
				// Stage k applies the (k+1)-th multiply when the exponent reaches it.
				f_s[k+1]    <= (mul_s[k] && (shininess > 8'(k))) ? prod[30:15] : f_s[k];
				base_s[k+1] <= base_s[k];
				mul_s[k+1]  <= mul_s[k];
				sin_s[k+1]  <= sin_s[k];
			end
		end
	end

	assign valid  = valid_s[N];
	assign sin_tl = sin_s[N];
	assign factor = f_s[N];

endmodule

>>> hdl/hss_color.sv
// ---------------------------------------------------------------------------
// Colour combine stages
// Diffuse and specular products per channel, then sum and saturation.
// ---------------------------------------------------------------------------
module hss_color (
	input  logic               clk,
	input  logic               arst_n,
	input  hss_pkg::pipe_ctl_t ctl,
	input  hss_pkg::rgb_t      diffuse,
	input  hss_pkg::rgb_t      specular,
	input  logic [15:0]        sin_tl,
	input  logic [15:0]        factor,
	output logic               valid,
	output hss_pkg::rgb_t      color
);

	logic          valid_c1, valid_c2;
	logic [31:0]   d_c1 [3];
	logic [31:0]   s_c1 [3];
	logic [15:0]   out_c2 [3];
	logic [17:0]   tot [3];

	for (genvar c = 0; c < 3; c++) begin : g_sum
		assign tot[c] = 18'(d_c1[c][31:15]) + 18'(s_c1[c][31:15]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_c1 <= 1'b0;
			valid_c2 <= 1'b0;
		end else if (ctl.en) begin
			valid_c1 <= ctl.valid;
			valid_c2 <= valid_c1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			d_c1[0] <= diffuse.red * sin_tl;
			d_c1[1] <= diffuse.green * sin_tl;
			d_c1[2] <= diffuse.blue * sin_tl;
			s_c1[0] <= specular.red * factor;
			s_c1[1] <= specular.green * factor;
			s_c1[2] <= specular.blue * factor;
			for (int c = 0; c < 3; c++) begin
				out_c2[c] <= (tot[c] > 18'd65535) ? 16'hFFFF : tot[c][15:0];
			end
		end
	end

	assign valid       = valid_c2;
	assign color.red   = out_c2[0];
	assign color.green = out_c2[1];
	assign color.blue  = out_c2[2];

endmodule

>>> hdl/hair_strand_shading_top.sv
// ---------------------------------------------------------------------------
// Hair strand shading top level
// Kajiya-Kay shading of one sample per beat, fully pipelined.
// ---------------------------------------------------------------------------
// A beat on the sample channel carries the strand tangent, light and eye
// directions in signed Q1.15. Each produces exactly one beat on the shade
// channel with the saturated Q4.12 colour, in order.
// The stages run in order: the cosines and radicands, the square roots,
// the specular base, the exponent multiplies (one per possible shininess
// step) and the colour sum.
// Throughput is one beat per cycle while the receiver does not stall; the exponent chain sets the depth.
// The configuration channel is always ready and writes one register per
// beat; writes are meant for when the pipeline is empty. Unknown indexes
// are ignored.
// Reset clears every valid bit and restores the colour and shininess
// registers to their defaults. When the receiver stalls the whole pipeline
// holds, and the sample channel drops ready until the result is taken.
// ---------------------------------------------------------------------------
module hair_strand_shading_top (
	input  logic       clk,
	input  logic       arst_n,
	hss_in_if.sink     sample,
	hss_out_if.source  shade,
	hss_cfg_if.sink    cfg
);

	hss_pkg::rgb_t      diffuse_q, specular_q;
	logic [7:0]         shininess_q;
	hss_pkg::pipe_ctl_t ctl_dot, ctl_sqrt, ctl_pow, ctl_col;
	hss_pkg::vec_set_t  vec;
	hss_pkg::rgb_t      color;
	logic               en;

	logic               dot_valid, sqrt_valid, pow_valid, col_valid;
	logic signed [17:0] dot_ctl, dot_cte, sq_ctl, sq_cte;
	logic [30:0]        rad_tl, rad_te;
	logic [15:0]        sq_sin_tl, sq_sin_te, pow_sin_tl, factor;

	assign en           = !col_valid || shade.ready;
	assign sample.ready = en;
	assign cfg.ready    = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			diffuse_q   <= '{red: hss_pkg::RST_DIFFUSE_RED, green: hss_pkg::RST_DIFFUSE_GREEN,
				blue: hss_pkg::RST_DIFFUSE_BLUE};
			specular_q  <= '{red: hss_pkg::RST_SPECULAR, green: hss_pkg::RST_SPECULAR,
				blue: hss_pkg::RST_SPECULAR};
			shininess_q <= hss_pkg::RST_SHININESS;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				hss_pkg::REG_DIFFUSE_RED:    diffuse_q.red    <= cfg.data;
				hss_pkg::REG_DIFFUSE_GREEN:  diffuse_q.green  <= cfg.data;
				hss_pkg::REG_DIFFUSE_BLUE:   diffuse_q.blue   <= cfg.data;
				hss_pkg::REG_SPECULAR_RED:   specular_q.red   <= cfg.data;
				hss_pkg::REG_SPECULAR_GREEN: specular_q.green <= cfg.data;
				hss_pkg::REG_SPECULAR_BLUE:  specular_q.blue  <= cfg.data;
				hss_pkg::REG_SHININESS:      shininess_q      <= cfg.data[7:0];
				default: ;
			endcase
		end
	end

	assign vec = '{tx: sample.tangent_x, ty: sample.tangent_y, tz: sample.tangent_z,
		lx: sample.light_x, ly: sample.light_y, lz: sample.light_z,
		ex: sample.eye_x, ey: sample.eye_y, ez: sample.eye_z};

	assign ctl_dot  = '{en: en, valid: sample.valid};
	assign ctl_sqrt = '{en: en, valid: dot_valid};
	assign ctl_pow  = '{en: en, valid: sqrt_valid};
	assign ctl_col  = '{en: en, valid: pow_valid};

	hss_dot u_dot (
		.clk, .arst_n, .ctl(ctl_dot), .vec,
		.valid(dot_valid), .cos_tl(dot_ctl), .cos_te(dot_cte), .rad_tl, .rad_te
	);

	hss_sqrt u_sqrt (
		.clk, .arst_n, .ctl(ctl_sqrt), .cos_tl_in(dot_ctl), .cos_te_in(dot_cte),
		.rad_tl, .rad_te, .valid(sqrt_valid), .cos_tl(sq_ctl), .cos_te(sq_cte),
		.sin_tl(sq_sin_tl), .sin_te(sq_sin_te)
	);

	hss_pow u_pow (
		.clk, .arst_n, .ctl(ctl_pow), .shininess(shininess_q), .cos_tl(sq_ctl),
		.cos_te(sq_cte), .sin_tl_in(sq_sin_tl), .sin_te(sq_sin_te),
		.valid(pow_valid), .sin_tl(pow_sin_tl), .factor
	);

	hss_color u_color (
		.clk, .arst_n, .ctl(ctl_col), .diffuse(diffuse_q), .specular(specular_q),
		.sin_tl(pow_sin_tl), .factor, .valid(col_valid), .color
	);

	assign shade.valid       = col_valid;
	assign shade.color_red   = color.red;
	assign shade.color_green = color.green;
	assign shade.color_blue  = color.blue;

endmodule

>>> bench/hss_tb_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Hair strand shading bench notes
// The bench reuses the design's channel interfaces; this file only holds
// the bench-side scoreboard entry type shared by the top module.
// ---------------------------------------------------------------------------
package hss_tb_pkg;

	typedef struct {
		logic [15:0] red;
		logic [15:0] green;
		logic [15:0] blue;
	} shade_exp_t;

endpackage

>>> bench/hair_strand_shading_top_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Hair strand shading testbench
// Drives sample vectors with random gaps and back-pressure, predicts each
// shaded colour in fixed point and compares it, in order, with the output.
// ---------------------------------------------------------------------------
module hair_strand_shading_top_tb;
	import hss_pkg::*;
	import hss_tb_pkg::*;

	localparam int LATENCY = 278;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	hss_in_if  sample ();
	hss_out_if shade ();
	hss_cfg_if cfg ();

	hair_strand_shading_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample.sink),
		.shade  (shade.source),
		.cfg    (cfg.sink)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	logic [15:0] diff_r, diff_g, diff_b, spec_r, spec_g, spec_b;
	logic [7:0]  shine;
	shade_exp_t  pending_shades[$];
	int          errors = 0;
	int          n_sent = 0;
	int          n_checked = 0;
	bit          gaps_on = 1'b1;
	int          hold_cycles = 0;

	initial begin
		sample.valid = 1'b0;
		{sample.tangent_x, sample.tangent_y, sample.tangent_z} = '0;
		{sample.light_x, sample.light_y, sample.light_z} = '0;
		{sample.eye_x, sample.eye_y, sample.eye_z} = '0;
		shade.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
	end

	function automatic longint floor_div15(longint x);
		return x >>> 15;
	endfunction

	function automatic longint int_sqrt(longint v);
		longint r = 0;
		longint b = 64'sd1 <<< 62;
		while (b > v) b = b >>> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >>> 1) + b;
			end else begin
				r = r >>> 1;
			end
			b = b >>> 2;
		end
		return r;
	endfunction

	function automatic longint sine_from_cos(longint c);
		longint rad = 64'sd1073741824 - c * c;
		if (rad < 0) rad = 0;
		return int_sqrt(rad);
	endfunction

	function automatic logic [15:0] mix_channel(logic [15:0] dc, logic [15:0] sc,
			longint s_tl, longint f);
		longint t = ((longint'(dc) * s_tl) >>> 15) + ((longint'(sc) * f) >>> 15);
		return (t > 65535) ? 16'hFFFF : t[15:0];
	endfunction

	function automatic shade_exp_t shade_sample(vec_set_t v);
		longint c_tl, c_te, s_tl, s_te, base_v, f;
		shade_exp_t r;
		c_tl = floor_div15(longint'(v.lx) * v.tx + longint'(v.ly) * v.ty
			+ longint'(v.lz) * v.tz);
		c_te = floor_div15(longint'(v.ex) * v.tx + longint'(v.ey) * v.ty
			+ longint'(v.ez) * v.tz);
		s_tl = sine_from_cos(c_tl);
		s_te = sine_from_cos(c_te);
		base_v = floor_div15(c_tl * c_te + s_tl * s_te);
		if (base_v <= 0) begin
			f = 0;
		end else if (base_v >= 32768) begin
			f = 32768;
		end else begin
			f = 32768;
			for (int k = 0; k < shine; k++) f = (f * base_v) >>> 15;
		end
		r.red   = mix_channel(diff_r, spec_r, s_tl, f);
		r.green = mix_channel(diff_g, spec_g, s_tl, f);
		r.blue  = mix_channel(diff_b, spec_b, s_tl, f);
		return r;
	endfunction

	// Leaves valid high; the caller drops it once the last write is done.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= val;
		do @(posedge clk); while (!cfg.ready);
		case (idx)
			REG_DIFFUSE_RED:    diff_r = val;
			REG_DIFFUSE_GREEN:  diff_g = val;
			REG_DIFFUSE_BLUE:   diff_b = val;
			REG_SPECULAR_RED:   spec_r = val;
			REG_SPECULAR_GREEN: spec_g = val;
			REG_SPECULAR_BLUE:  spec_b = val;
			REG_SHININESS:      shine = val[7:0];
			default: ;
		endcase
	endtask

	task automatic sample_idle();
		sample.valid <= 1'b0;
	endtask

	task automatic drain();
		sample_idle();
		while (pending_shades.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	task automatic set_colours(logic [15:0] dr, logic [15:0] dg, logic [15:0] db,
			logic [15:0] sr, logic [15:0] sg, logic [15:0] sb, logic [7:0] sh);
		drain();
		write_reg(REG_DIFFUSE_RED, dr);
		write_reg(REG_DIFFUSE_GREEN, dg);
		write_reg(REG_DIFFUSE_BLUE, db);
		write_reg(REG_SPECULAR_RED, sr);
		write_reg(REG_SPECULAR_GREEN, sg);
		write_reg(REG_SPECULAR_BLUE, sb);
		write_reg(REG_SHININESS, {8'd0, sh});
		cfg.valid <= 1'b0;
	endtask

	// One beat on the sample channel; the expectation is queued on acceptance.
	// Valid stays high after the beat so that beats can follow back to back.
	task automatic send_sample(vec_set_t v);
		while (gaps_on && $urandom_range(99) < 16) begin
			sample.valid <= 1'b0;
			@(posedge clk);
		end
		sample.valid <= 1'b1;
		{sample.tangent_x, sample.tangent_y, sample.tangent_z} <= {v.tx, v.ty, v.tz};
		{sample.light_x, sample.light_y, sample.light_z} <= {v.lx, v.ly, v.lz};
		{sample.eye_x, sample.eye_y, sample.eye_z} <= {v.ex, v.ey, v.ez};
		do @(posedge clk); while (!sample.ready);
		pending_shades.push_back(shade_sample(v));
		n_sent++;
	endtask

	function automatic vec_set_t random_set();
		vec_set_t    v;
		logic [159:0] bits;
		bits = {$urandom, $urandom, $urandom, $urandom, $urandom};
		v = vec_set_t'(bits[143:0]);
		return v;
	endfunction

	// Roughly unit vectors: one axis near plus or minus one, the others small.
	function automatic logic signed [15:0] near_unit(bit big);
		if (big) return $urandom_range(1) ? 16'(32767 - int'($urandom_range(3000)))
			: 16'(-32768 + int'($urandom_range(3000)));
		return 16'(int'($urandom_range(8000)) - 4000);
	endfunction

	function automatic vec_set_t shaped_set();
		vec_set_t v;
		int a = $urandom_range(2);
		int b = $urandom_range(2);
		int e = $urandom_range(2);
		v.tx = near_unit(a == 0); v.ty = near_unit(a == 1); v.tz = near_unit(a == 2);
		v.lx = near_unit(b == 0); v.ly = near_unit(b == 1); v.lz = near_unit(b == 2);
		v.ex = near_unit(e == 0); v.ey = near_unit(e == 1); v.ez = near_unit(e == 2);
		return v;
	endfunction

	always @(posedge clk) begin
		shade_exp_t x;
		if (shade.valid && shade.ready) begin
			if (pending_shades.size() == 0) begin
				$error("shade beat with no expectation");
				errors++;
			end else begin
				x = pending_shades.pop_front();
				if (shade.color_red !== x.red) begin
					$error("color_red exp %0d got %0d", x.red, shade.color_red);
					errors++;
				end
				if (shade.color_green !== x.green) begin
					$error("color_green exp %0d got %0d", x.green, shade.color_green);
					errors++;
				end
				if (shade.color_blue !== x.blue) begin
					$error("color_blue exp %0d got %0d", x.blue, shade.color_blue);
					errors++;
				end
				n_checked++;
			end
		end
	end

	// Receiver: random stalls, or a long hold counted in cycles.
	always @(posedge clk) begin
		if (!arst_n) begin
			shade.ready <= 1'b0;
		end else if (hold_cycles > 0) begin
			shade.ready <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else begin
			shade.ready <= !(gaps_on && $urandom_range(99) < 16);
		end
	end

	task automatic test_directed();
		vec_set_t v;
		logic signed [15:0] ext[4] = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'sh4000};
		// Parallel light and eye: base just below one.
		v = '{16'sh7FFF, 0, 0, 16'sh7FFF, 0, 0, 16'sh7FFF, 0, 0};
		send_sample(v);
		// Perpendicular vectors: full sines.
		v = '{16'sh7FFF, 0, 0, 0, 16'sh7FFF, 0, 0, 0, 16'sh7FFF};
		send_sample(v);
		// Opposed light and eye: negative base.
		v = '{16'sh7FFF, 0, 0, 16'sh7FFF, 0, 0, 16'sh8000, 0, 0};
		send_sample(v);
		// Oversized vectors: negative radicand.
		v = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
			16'sh7FFF, 16'sh7FFF, 16'sh7FFF};
		send_sample(v);
		v = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
		send_sample(v);
		v = '{16'sh5A82, 16'sh5A82, 0, 16'sh7FFF, 0, 0, 0, 16'sh7FFF, 0};
		send_sample(v);
		for (int i = 0; i < 12; i++) begin
			v = '{ext[i%4], ext[(i+1)%4], ext[(i+2)%4], ext[(i+3)%4], ext[i%4],
				ext[(i+2)%4], ext[(i+1)%4], ext[(i+3)%4], ext[(i+2)%4]};
			send_sample(v);
		end
	endtask

	task automatic test_extreme_colours();
		vec_set_t v;
		// Saturation: largest colours and exponent.
		set_colours(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd255);
		for (int i = 0; i < 40; i++) send_sample(shaped_set());
		v = '{16'sh7FFF, 0, 0, 0, 16'sh7FFF, 0, 0, 16'sh7FFF, 0};
		send_sample(v);
		set_colours(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'd1);
		for (int i = 0; i < 30; i++) send_sample(shaped_set());
		// Zero exponent and an unused index.
		set_colours(16'h1234, 16'h8000, 16'h0001, 16'h7FFF, 16'h1000, 16'hFFFE, 8'd0);
		write_reg(3'd7, 16'hFFFF);
		cfg.valid <= 1'b0;
		for (int i = 0; i < 30; i++) send_sample(shaped_set());
	endtask

	task automatic test_random(int n);
		for (int i = 0; i < n; i++) begin
			if (i % 150 == 0)
				set_colours(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom), 16'($urandom), 8'($urandom_range(255, 1)));
			send_sample(($urandom_range(9) < 7) ? shaped_set() : random_set());
		end
	endtask

	task automatic test_pressure();
		gaps_on = 1'b0;
		for (int i = 0; i < 200; i++) send_sample(shaped_set());
		// Hold the receiver well past the pipeline depth while samples keep coming.
		hold_cycles = 2 * LATENCY;
		for (int i = 0; i < 500; i++) send_sample(random_set());
		gaps_on = 1'b1;
		sample_idle();
		while (pending_shades.size() != 0) @(posedge clk);
		for (int i = 0; i < 30; i++) send_sample(shaped_set());
	endtask

	initial begin
		diff_r = RST_DIFFUSE_RED; diff_g = RST_DIFFUSE_GREEN; diff_b = RST_DIFFUSE_BLUE;
		spec_r = RST_SPECULAR; spec_g = RST_SPECULAR; spec_b = RST_SPECULAR;
		shine = RST_SHININESS;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_extreme_colours();
		test_random(450);
		test_pressure();
		sample_idle();
		while (pending_shades.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		$display("Covered %0d samples, %0d colours checked, over reset, extreme and",
			n_sent, n_checked);
		$display("random register settings, with stalls and a long receiver hold.");
		if (errors == 0 && pending_shades.size() == 0) begin
			$display("hair_strand_shading_top_tb OK");
		end else begin
			$display("hair_strand_shading_top_tb NOT OK");
		end
		$finish;
	end

	initial begin
		#40ms;
		$display("hair_strand_shading_top_tb NOT OK");
		$finish;
	end

endmodule
